FILE: hw/rtl/assert_macros.svh
// assertion helpers, clocked on clk and off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/bce_pkg.sv
package bce_pkg;

    localparam int MAX_ROWS = 65535;
    localparam int SP_DEPTH = 256;

    localparam int ROW_W = $clog2(MAX_ROWS + 1);
    localparam int IDX_W = $clog2(SP_DEPTH);
    localparam int SUM_W = 48;
    localparam int TAIL_W = 16;
    localparam int DIM_W = 17;

    localparam logic [1:0] OP_LOGIT = 2'd0;
    localparam logic [1:0] OP_LABEL = 2'd1;

    // -ln(1e-7) in Q16.16
    localparam logic [23:0] NEG_LN_EPS = 24'd1056316;
    localparam logic [16:0] T_ONE = 17'd65536;
    localparam logic [DIM_W-1:0] DIM_RESET = 17'd65536;

    localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_START,
        S_DIV,
        S_LOAD
    } state_t;

    typedef struct packed {
        logic capture;
        logic add;
        logic div_start;
        logic load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic batch_end;
        logic div_done;
    } dp_status_t;

    typedef logic [TAIL_W-1:0] tail_tbl_t [SP_DEPTH];

    // unsigned quotient by shift and subtract, used only while building the table
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] rem;
        q = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, d})
            begin
                rem = rem - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // ln(1 + exp(-a)), a in Q16.16 below 16.0, result Q16.16
    function automatic logic [TAIL_W-1:0] softplus_tail(input logic [63:0] a);
        logic [63:0] g;
        logic [63:0] term;
        logic [63:0] r;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] p;
        logic [63:0] s;
        logic [63:0] rnd;
        logic signed [64:0] sum;
        g = a << 12;
        term = ONE_Q32;
        sum = $signed({1'b0, ONE_Q32});
        // exp(-a/16) by series
        for (int k = 1; k <= 24; k++)
        begin
            term = udiv64((term * g) >> 32, 64'(k));
            if ((k & 1) != 0)
                sum = sum - $signed({1'b0, term});
            else
                sum = sum + $signed({1'b0, term});
        end
        if (sum < 0)
            sum = '0;
        r = sum[63:0];
        if (r > ONE_Q32 - 64'd1)
            r = ONE_Q32 - 64'd1;
        // raise to the 16th power
        for (int k = 0; k < 4; k++)
        begin
            r = (r * r + 64'd2147483648) >> 32;
            if (r > ONE_Q32 - 64'd1)
                r = ONE_Q32 - 64'd1;
        end
        // ln(1+e) = 2 atanh(e / (2+e))
        z = udiv64(r << 32, 64'd2 * ONE_Q32 + r);
        z2 = (z * z) >> 32;
        p = z;
        s = z;
        for (int k = 1; k <= 20; k++)
        begin
            p = (p * z2) >> 32;
            s = s + udiv64(p, 64'(2 * k + 1));
        end
        rnd = (64'd2 * s + 64'd32768) >> 16;
        return rnd[TAIL_W-1:0];
    endfunction

    function automatic tail_tbl_t build_tail_table();
        tail_tbl_t tbl;
        for (int k = 0; k < SP_DEPTH; k++)
            tbl[k] = softplus_tail(64'((2 * k + 1) << (19 - IDX_W)));
        return tbl;
    endfunction

    localparam tail_tbl_t TAIL_TABLE = build_tail_table();

endpackage

FILE: hw/rtl/bce_loss_accumulator.sv
// channel  | handshake                    | payload
// ---------+------------------------------+--------------------------------------------
// input    | in_valid / in_ready          | op logit label_value column last_in_row
//          |                              | last_in_batch
// output   | out_valid / out_ready        | mean_loss bad_label rows_seen
// config   | dim_we (no wait)             | dim_wdata
//
// an item goes through capture with multiply and table lookup, then the add
// an item closing the batch then goes through start, a bit-serial divide of the
// loss sum by the row count, and load
// the result waits in an output register; the next item is taken while it waits
// reset clears the sums, counters, flags and sets dim to 65536
module bce_loss_accumulator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        dim_we,
    input  logic [bce_pkg::DIM_W-1:0]   dim_wdata,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  op,
    input  logic signed [23:0]          logit,
    input  logic [16:0]                 label_value,
    input  logic [15:0]                 column,
    input  logic                        last_in_row,
    input  logic                        last_in_batch,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [31:0]                 mean_loss,
    output logic                        bad_label,
    output logic [15:0]                 rows_seen
);
    import bce_pkg::*;

    `include "assert_macros.svh"

    ctrl_cmd_t  cmd;
    dp_status_t status;

    bce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    bce_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .dim_we        (dim_we),
        .dim_wdata     (dim_wdata),
        .op            (op),
        .logit         (logit),
        .label_value   (label_value),
        .column        (column),
        .last_in_row   (last_in_row),
        .last_in_batch (last_in_batch),
        .mean_loss     (mean_loss),
        .bad_label     (bad_label),
        .rows_seen     (rows_seen)
    );

    `ASSERT_NEXT(a_busy_after_item, in_valid && in_ready, !in_ready, "item taken while busy")
    `ASSERT_NEXT(a_load_shows_result, cmd.load, out_valid, "loaded result not shown")
    `ASSERT_SAME(a_rows_nonzero, out_valid, rows_seen != 16'd0, "result with no rows")

endmodule

FILE: hw/rtl/bce_div.sv
module bce_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [bce_pkg::SUM_W-1:0]  dividend,
    input  logic [bce_pkg::ROW_W-1:0]  divisor,
    output logic                       done,
    output logic [bce_pkg::SUM_W-1:0]  quotient
);
    import bce_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);

    logic               busy_reg, busy_next;
    logic [STEP_W-1:0]  cnt_reg, cnt_next;
    logic [SUM_W-1:0]   quo_reg, quo_next;
    logic [ROW_W-1:0]   rem_reg, rem_next;
    logic [ROW_W:0]     rem_sh;
    logic               fits;
    logic               last_step;

    assign last_step = cnt_reg == STEP_W'(SUM_W - 1);
    assign done = busy_reg && last_step;
    assign quotient = quo_reg;

    // one quotient bit per cycle, restoring
    assign rem_sh = {rem_reg, quo_reg[SUM_W-1]};
    assign fits = rem_sh >= {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = '0;
            quo_next = dividend;
            rem_next = '0;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[SUM_W-2:0], fits};
            rem_next = fits ? ROW_W'(rem_sh - {1'b0, divisor}) : rem_sh[ROW_W-1:0];
            cnt_next = cnt_reg + STEP_W'(1);
            if (last_step)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

endmodule

FILE: hw/rtl/bce_dpath.sv
module bce_dpath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bce_pkg::ctrl_cmd_t          cmd,
    output bce_pkg::dp_status_t         status,
    input  logic                        dim_we,
    input  logic [bce_pkg::DIM_W-1:0]   dim_wdata,
    input  logic [1:0]                  op,
    input  logic signed [23:0]          logit,
    input  logic [16:0]                 label_value,
    input  logic [15:0]                 column,
    input  logic                        last_in_row,
    input  logic                        last_in_batch,
    output logic [31:0]                 mean_loss,
    output logic                        bad_label,
    output logic [15:0]                 rows_seen
);
    import bce_pkg::*;

    logic [DIM_W-1:0]    dim_reg;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [ROW_W-1:0]    rows_reg, rows_next;
    logic                err_reg, err_next;
    logic                batch_reg;

    logic signed [41:0]  prod_reg;
    logic [22:0]         pos_reg;
    logic [TAIL_W-1:0]   tail_reg;
    logic                logit_reg;
    logic                label_reg;

    logic [31:0]         mean_reg;
    logic                bad_reg;
    logic [15:0]         rows_out_reg;

    // capture side
    logic [16:0]         t_clip;
    logic signed [23:0]  mult_b;
    logic signed [41:0]  prod;
    logic [23:0]         abs_x;
    logic [31:0]         scaled;
    logic [IDX_W-1:0]    idx;
    logic [TAIL_W-1:0]   tail;
    logic                is_logit;
    logic                is_label;
    logic                closes_row;

    // add side
    logic signed [41:0]  prod_rnd;
    logic signed [27:0]  tx_s;
    logic signed [27:0]  term;
    logic [SUM_W-1:0]    add_val;
    logic [SUM_W:0]      sum_wide;

    logic                div_done;
    logic [SUM_W-1:0]    quotient;
    logic [31:0]         rows32;

    assign is_logit = op == OP_LOGIT;
    assign is_label = op == OP_LABEL;
    assign closes_row = last_in_row || last_in_batch || !(is_logit || is_label);

    assign t_clip = (label_value > T_ONE) ? T_ONE : label_value;
    assign mult_b = is_logit ? logit : $signed(NEG_LN_EPS);
    assign prod = $signed({1'b0, t_clip}) * mult_b;

    assign abs_x = logit[23] ? (~logit + 24'd1) : logit;
    assign scaled = (32'(abs_x) * 32'(SP_DEPTH)) >> 20;
    assign idx = scaled[IDX_W-1:0];
    // tail is zero from 16.0 up
    assign tail = (abs_x < 24'h100000) ? TAIL_TABLE[idx] : '0;

    // round half up, same rule for both signs
    assign prod_rnd = prod_reg + 42'sd32768;
    assign tx_s = {{2{prod_rnd[41]}}, prod_rnd[41:16]};
    assign term = logit_reg ? ($signed({5'b0, pos_reg}) + $signed({12'b0, tail_reg}) - tx_s)
                            : tx_s;
    assign add_val = (term > 28'sd0) ? SUM_W'(term[26:0]) : '0;
    assign sum_wide = {1'b0, sum_reg} + {1'b0, add_val};

    assign rows32 = 32'(rows_reg);

    always_comb
    begin
        sum_next = sum_reg;
        rows_next = rows_reg;
        err_next = err_reg;
        if (cmd.capture)
        begin
            if ((is_logit || is_label) && ({1'b0, column} >= dim_reg))
                err_next = 1'b1;
            if (closes_row && rows_reg < ROW_W'(MAX_ROWS))
                rows_next = rows_reg + ROW_W'(1);
        end
        if (cmd.add && (logit_reg || label_reg))
            sum_next = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
        if (cmd.load)
        begin
            sum_next = '0;
            rows_next = '0;
            err_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg <= DIM_RESET;
            sum_reg <= '0;
            rows_reg <= '0;
            err_reg <= 1'b0;
        end
        else
        begin
            if (dim_we)
                dim_reg <= dim_wdata;
            sum_reg <= sum_next;
            rows_reg <= rows_next;
            err_reg <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            prod_reg <= prod;
            pos_reg <= logit[23] ? '0 : logit[22:0];
            tail_reg <= tail;
            logit_reg <= is_logit;
            label_reg <= is_label;
            batch_reg <= last_in_batch;
        end
        if (cmd.load)
        begin
            if (rows_reg == '0)
                mean_reg <= '0;
            else if (|quotient[SUM_W-1:32])
                mean_reg <= '1;
            else
                mean_reg <= quotient[31:0];
            bad_reg <= err_reg;
            rows_out_reg <= (rows32 > 32'd65535) ? 16'hFFFF : rows32[15:0];
        end
    end

    bce_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (rows_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign status.batch_end = batch_reg;
    assign status.div_done = div_done;

    assign mean_loss = mean_reg;
    assign bad_label = bad_reg;
    assign rows_seen = rows_out_reg;

endmodule

FILE: hw/rtl/bce_ctrl.sv
module bce_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  bce_pkg::dp_status_t  status,
    output bce_pkg::ctrl_cmd_t   cmd
);
    import bce_pkg::*;

    state_t state_reg, state_next;
    logic   full_reg, full_next;
    logic   slot_free;

    // output slot can take a new result when empty or emptying now
    assign slot_free = !full_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_ADD;
            end
            S_ADD:
            begin
                state_next = status.batch_end ? S_START : S_IDLE;
            end
            S_START:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (status.div_done)
                    state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.capture = in_valid;
            end
            S_ADD:
            begin
                cmd.add = 1'b1;
            end
            S_START:
            begin
                cmd.div_start = 1'b1;
            end
            S_DIV:
            begin
                cmd = '0;
            end
            S_LOAD:
            begin
                cmd.load = slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        full_next = full_reg;
        if (cmd.load)
            full_next = 1'b1;
        else if (out_ready)
            full_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            full_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            full_reg <= full_next;
        end
    end

    assign out_valid = full_reg;

endmodule
